// ===== hw/rtl/wpf_pkg.sv =====
// shared types and constants of the windowed peak finder
`timescale 1ns / 1ps

package wpf_pkg;

  localparam int CfgDataBits = 13;
  localparam int CfgIndexBits = 3;
  localparam int PixBits = 8;
  localparam int LimitBits = 9;
  localparam int OutCoordBits = 12;

  localparam logic [CfgIndexBits-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CfgIndexBits-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CfgIndexBits-1:0] REG_BOX_LEFT     = 3'd2;
  localparam logic [CfgIndexBits-1:0] REG_BOX_TOP      = 3'd3;
  localparam logic [CfgIndexBits-1:0] REG_BOX_RIGHT    = 3'd4;
  localparam logic [CfgIndexBits-1:0] REG_BOX_BOTTOM   = 3'd5;
  localparam logic [CfgIndexBits-1:0] REG_VALUE_LIMIT  = 3'd6;

  localparam logic [CfgDataBits-1:0] RST_IMAGE_WIDTH  = 13'd640;
  localparam logic [CfgDataBits-1:0] RST_IMAGE_HEIGHT = 13'd480;
  localparam logic [CfgDataBits-1:0] RST_BOX_LEFT     = 13'd0;
  localparam logic [CfgDataBits-1:0] RST_BOX_TOP      = 13'd0;
  localparam logic [CfgDataBits-1:0] RST_BOX_RIGHT    = 13'd640;
  localparam logic [CfgDataBits-1:0] RST_BOX_BOTTOM   = 13'd480;
  localparam logic [LimitBits-1:0]   RST_VALUE_LIMIT  = 9'd256;

  typedef struct packed {
    logic [CfgDataBits-1:0] image_width;
    logic [CfgDataBits-1:0] image_height;
    logic [CfgDataBits-1:0] box_left;
    logic [CfgDataBits-1:0] box_top;
    logic [CfgDataBits-1:0] box_right;
    logic [CfgDataBits-1:0] box_bottom;
    logic [LimitBits-1:0]   value_limit;
  } cfg_t;

  typedef struct packed {
    logic hit;
    logic row_end;
    logic frame_end;
  } eval_t;

endpackage

// ===== hw/rtl/wpf_eval.sv =====
// per-pixel box, limit and end-of-row/frame evaluation
`timescale 1ns / 1ps

module wpf_eval
  import wpf_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  cfg_t                  cfg,
  input  logic [COORD_BITS-1:0] col,
  input  logic [COORD_BITS-1:0] row,
  input  logic [PixBits-1:0]    pix,
  input  logic [PixBits-1:0]    best_level,
  output eval_t                 ev
);

  localparam int EW = (COORD_BITS + 2 > 14) ? COORD_BITS + 2 : 14;
  localparam logic [EW-1:0] DimLim = EW'(1) << COORD_BITS;

  logic [EW-1:0] w_wide;
  logic [EW-1:0] h_wide;
  logic [COORD_BITS-1:0] w_m1;
  logic [COORD_BITS-1:0] h_m1;
  logic [EW-1:0] col_wide;
  logic [EW-1:0] row_wide;
  logic in_x;
  logic in_y;
  logic lim_ok;

  // last column / row index, with zero acting as one and clamping at the coord range
  function automatic logic [COORD_BITS-1:0] last_idx(input logic [EW-1:0] d);
    logic [EW-1:0] r;
    if (d == '0) begin
      r = '0;
    end else if (d > DimLim) begin
      r = DimLim - EW'(1);
    end else begin
      r = d - EW'(1);
    end
    return r[COORD_BITS-1:0];
  endfunction

  assign w_wide   = EW'(cfg.image_width);
  assign h_wide   = EW'(cfg.image_height);
  assign w_m1     = last_idx(w_wide);
  assign h_m1     = last_idx(h_wide);
  assign col_wide = EW'(col);
  assign row_wide = EW'(row);

  assign in_x = (cfg.box_left[CfgDataBits-1] ||
                 col_wide >= EW'(cfg.box_left[CfgDataBits-2:0])) &&
                (col_wide < EW'(cfg.box_right)) && (col <= w_m1);
  assign in_y = (cfg.box_top[CfgDataBits-1] ||
                 row_wide >= EW'(cfg.box_top[CfgDataBits-2:0])) &&
                (row_wide < EW'(cfg.box_bottom)) && (row <= h_m1);
  assign lim_ok = {1'b0, pix} < cfg.value_limit;

  assign ev.hit       = in_x && in_y && lim_ok && (pix > best_level);
  assign ev.row_end   = col >= w_m1;
  assign ev.frame_end = (col >= w_m1) && (row >= h_m1);

endmodule

// ===== hw/rtl/windowed_peak_below_limit_finder.sv =====
// top level of the windowed peak finder
`timescale 1ns / 1ps
// Finds the brightest pixel strictly below a value limit inside a search box.
// Input channel: one 8-bit pixel per beat (in_valid/in_stall), raster order.
// Frame size and box come from the cfg_ write port (index, 13-bit data).
// Result channel: one beat per frame (out_valid/out_stall) carrying found,
// column, row and value of the first pixel with the largest qualifying value;
// all zero when nothing qualified.
// Throughput: one pixel per clock while in_stall is low, set by a single
// compare-and-keep stage between the pixel register and the result register.
// A frame's last pixel enters the pixel register, then its result the result register.
// Reset clears counters, best candidate and both valid flags, and loads the
// default config (640 x 480, full-frame box, no value limit).
// If a finished result is still stalled when the next frame's last pixel is
// ready, in_stall rises and holds the pipeline until the result is taken;
// otherwise pixels keep flowing while the result waits.
module windowed_peak_below_limit_finder
  import wpf_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CfgIndexBits-1:0] cfg_index,
  input  logic [CfgDataBits-1:0]  cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [PixBits-1:0]      in_pixel_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_found,
  output logic [OutCoordBits-1:0] out_best_x,
  output logic [OutCoordBits-1:0] out_best_y,
  output logic [PixBits-1:0]      out_best_value
);

  cfg_t cfg_r;
  logic pix_valid_r;
  logic [PixBits-1:0] pix_r;
  logic [COORD_BITS-1:0] col_r;
  logic [COORD_BITS-1:0] row_r;
  logic [PixBits-1:0] best_level_r;
  logic [COORD_BITS-1:0] best_col_r;
  logic [COORD_BITS-1:0] best_row_r;
  logic out_valid_r;
  logic out_found_r;
  logic [OutCoordBits-1:0] out_x_r;
  logic [OutCoordBits-1:0] out_y_r;
  logic [PixBits-1:0] out_value_r;

  eval_t ev;
  logic busy;
  logic accept;
  logic step;
  logic [PixBits-1:0] lvl_nxt;
  logic [COORD_BITS-1:0] bcol_nxt;
  logic [COORD_BITS-1:0] brow_nxt;
  logic [COORD_BITS+OutCoordBits-1:0] x_ext;
  logic [COORD_BITS+OutCoordBits-1:0] y_ext;

  wpf_eval #(.COORD_BITS(COORD_BITS)) u_eval (
    .cfg        (cfg_r),
    .col        (col_r),
    .row        (row_r),
    .pix        (pix_r),
    .best_level (best_level_r),
    .ev         (ev)
  );

  assign busy     = pix_valid_r && ev.frame_end && out_valid_r && out_stall;
  assign in_stall = busy;
  assign accept   = in_valid && !busy;
  assign step     = pix_valid_r && !busy;

  assign lvl_nxt  = ev.hit ? pix_r : best_level_r;
  assign bcol_nxt = ev.hit ? col_r : best_col_r;
  assign brow_nxt = ev.hit ? row_r : best_row_r;
  assign x_ext    = {{OutCoordBits{1'b0}}, bcol_nxt};
  assign y_ext    = {{OutCoordBits{1'b0}}, brow_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width  <= RST_IMAGE_WIDTH;
      cfg_r.image_height <= RST_IMAGE_HEIGHT;
      cfg_r.box_left     <= RST_BOX_LEFT;
      cfg_r.box_top      <= RST_BOX_TOP;
      cfg_r.box_right    <= RST_BOX_RIGHT;
      cfg_r.box_bottom   <= RST_BOX_BOTTOM;
      cfg_r.value_limit  <= RST_VALUE_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  cfg_r.image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: cfg_r.image_height <= cfg_data;
        REG_BOX_LEFT:     cfg_r.box_left     <= cfg_data;
        REG_BOX_TOP:      cfg_r.box_top      <= cfg_data;
        REG_BOX_RIGHT:    cfg_r.box_right    <= cfg_data;
        REG_BOX_BOTTOM:   cfg_r.box_bottom   <= cfg_data;
        REG_VALUE_LIMIT:  cfg_r.value_limit  <= cfg_data[LimitBits-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_valid_r  <= 1'b0;
      col_r        <= '0;
      row_r        <= '0;
      best_level_r <= '0;
      best_col_r   <= '0;
      best_row_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (accept) begin
        pix_valid_r <= 1'b1;
        pix_r       <= in_pixel_value;
      end else if (step) begin
        pix_valid_r <= 1'b0;
      end
      if (step && ev.frame_end) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (step) begin
        if (ev.frame_end) begin
          out_found_r  <= lvl_nxt != '0;
          out_x_r      <= x_ext[OutCoordBits-1:0];
          out_y_r      <= y_ext[OutCoordBits-1:0];
          out_value_r  <= lvl_nxt;
          col_r        <= '0;
          row_r        <= '0;
          best_level_r <= '0;
          best_col_r   <= '0;
          best_row_r   <= '0;
        end else begin
          best_level_r <= lvl_nxt;
          best_col_r   <= bcol_nxt;
          best_row_r   <= brow_nxt;
          if (ev.row_end) begin
            col_r <= '0;
            row_r <= row_r + COORD_BITS'(1);
          end else begin
            col_r <= col_r + COORD_BITS'(1);
          end
        end
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_best_x     = out_x_r;
  assign out_best_y     = out_y_r;
  assign out_best_value = out_value_r;

endmodule

// ===== hw/rtl/wpf_checker.sv =====
// port-level assertions of the windowed peak finder and their bind
`timescale 1ns / 1ps

module wpf_checker
  import wpf_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic                    out_found,
  input logic [OutCoordBits-1:0] out_best_x,
  input logic [OutCoordBits-1:0] out_best_y,
  input logic [PixBits-1:0]      out_best_value
);

  // a stalled result beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_found) &&
      $stable(out_best_x) && $stable(out_best_y) && $stable(out_best_value))
    else $error("result beat changed while stalled");

  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // empty result carries zero fields
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_best_x == '0 && out_best_y == '0 &&
      out_best_value == '0)
    else $error("empty result with nonzero fields");

  a_found_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_best_value != '0)
    else $error("found result with zero value");

  // input backpressure only comes from a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

endmodule

bind windowed_peak_below_limit_finder wpf_checker u_wpf_checker (.*);

// ===== dv/tb_windowed_peak_below_limit_finder.sv =====
// testbench for the windowed peak finder: directed and random frames checked against a peak tracker
`timescale 1ns / 1ps

module tb_windowed_peak_below_limit_finder;
  import wpf_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int DRAIN_CYCLES = 4;
  localparam int RAND_PIXELS = 1050;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_DIM = 4096;
  localparam int RAMP_PIXELS = 128;

  typedef struct packed {
    logic                    found;
    logic [OutCoordBits-1:0] x;
    logic [OutCoordBits-1:0] y;
    logic [PixBits-1:0]      level;
  } peak_t;

  typedef enum int {IDLE_RX_HEAVY, IDLE_TX_HEAVY, IDLE_OFF} idle_mode_e;

  logic                    clk;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CfgIndexBits-1:0] cfg_index = '0;
  logic [CfgDataBits-1:0]  cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [PixBits-1:0]      in_pixel_value = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    out_found;
  logic [OutCoordBits-1:0] out_best_x;
  logic [OutCoordBits-1:0] out_best_y;
  logic [PixBits-1:0]      out_best_value;

  windowed_peak_below_limit_finder dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_pixel_value(in_pixel_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_found     (out_found),
    .out_best_x    (out_best_x),
    .out_best_y    (out_best_y),
    .out_best_value(out_best_value)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  cfg_t                    shadow;
  logic [OutCoordBits-1:0] col_cnt;
  logic [OutCoordBits-1:0] row_cnt;
  logic [OutCoordBits-1:0] best_col;
  logic [OutCoordBits-1:0] best_row;
  logic [PixBits-1:0]      best_lvl;

  peak_t              peak_q[$];
  logic [PixBits-1:0] pix_q[$];
  idle_mode_e         idle_mode = IDLE_RX_HEAVY;
  logic               in_took = 1'b0;
  bit                 hold_arm = 1'b0;
  bit                 hold_started = 1'b0;
  int                 hold_left = 0;
  int                 err_cnt = 0;
  int                 pix_cnt = 0;
  int                 frame_cnt = 0;
  int                 stall_cnt = 0;
  int                 cycle_cnt = 0;

  function automatic int eff_dim(input logic [CfgDataBits-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  function automatic int clip_low(input logic [CfgDataBits-1:0] v);
    int e;
    e = $signed(v);
    return (e < 0) ? 0 : e;
  endfunction

  // compare-and-keep over one pixel; returns 1 when the pixel closes a frame
  function automatic bit track_pixel(input logic [PixBits-1:0] pix, output peak_t res);
    int w;
    int h;
    int x1;
    int y1;
    bit row_end;
    w = eff_dim(shadow.image_width);
    h = eff_dim(shadow.image_height);
    x1 = (int'(shadow.box_right) < w) ? int'(shadow.box_right) : w;
    y1 = (int'(shadow.box_bottom) < h) ? int'(shadow.box_bottom) : h;
    res = '0;
    if (int'(col_cnt) >= clip_low(shadow.box_left) && int'(col_cnt) < x1 &&
        int'(row_cnt) >= clip_low(shadow.box_top) && int'(row_cnt) < y1 &&
        {1'b0, pix} < shadow.value_limit && pix > best_lvl) begin
      best_lvl = pix;
      best_col = col_cnt;
      best_row = row_cnt;
    end
    row_end = int'(col_cnt) >= w - 1;
    if (row_end && int'(row_cnt) >= h - 1) begin
      if (best_lvl != 0) res = '{1'b1, best_col, best_row, best_lvl};
      col_cnt = '0;
      row_cnt = '0;
      best_lvl = '0;
      best_col = '0;
      best_row = '0;
      return 1'b1;
    end
    if (row_end) begin
      col_cnt = '0;
      row_cnt = row_cnt + 1'b1;
    end else begin
      col_cnt = col_cnt + 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit roll_idle(input bit rx_side);
    int pct;
    case (idle_mode)
      IDLE_RX_HEAVY: pct = rx_side ? 76 : 11;
      IDLE_TX_HEAVY: pct = rx_side ? 11 : 76;
      default:       pct = 0;
    endcase
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic logic [PixBits-1:0] pick_level(input logic [LimitBits-1:0] lim);
    int t;
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 8'd255;
      2: return 8'($urandom_range(1, 4));
      3: begin
        t = int'(lim) - 2 + int'($urandom_range(0, 3));
        if (t < 0) t = 0;
        if (t > 255) t = 255;
        return 8'(t);
      end
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [CfgDataBits-1:0] pick_dim(input int top);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 13'd1;
      default: return 13'($urandom_range(2, top));
    endcase
  endfunction

  function automatic logic [CfgDataBits-1:0] pick_low_edge(input int span);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return {1'b1, 12'($urandom)};
      5: return 13'($urandom);
      default: return 13'($urandom_range(0, span - 1));
    endcase
  endfunction

  function automatic logic [CfgDataBits-1:0] pick_high_edge(input int span);
    case ($urandom_range(0, 5))
      0: return 13'h1FFF;
      1: return 13'($urandom);
      5: return 13'(span);
      default: return 13'($urandom_range(0, span + 1));
    endcase
  endfunction

  function automatic logic [LimitBits-1:0] pick_limit();
    case ($urandom_range(0, 4))
      0: return 9'd256;
      1: return 9'($urandom_range(0, 1));
      4: return 9'($urandom_range(128, 256));
      default: return 9'($urandom_range(2, 256));
    endcase
  endfunction

  // pixel driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (pix_q.size() != 0 && !roll_idle(1'b0)) begin
        in_valid <= 1'b1;
        in_pixel_value <= pix_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result-side back-pressure
  always @(negedge clk) begin
    if (hold_arm && !hold_started) begin
      hold_started = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= roll_idle(1'b1);
    end
  end

  // monitor: predict on each pixel beat, check each result beat
  always @(posedge clk) begin
    peak_t nxt;
    peak_t got;
    peak_t want;
    if (rst_n) begin
      in_took <= in_valid && !in_stall;
      if (in_valid && in_stall) stall_cnt++;
      if (in_valid && !in_stall) begin
        pix_cnt++;
        if (track_pixel(in_pixel_value, nxt)) peak_q.push_back(nxt);
      end
      if (out_valid && !out_stall) begin
        got = '{out_found, out_best_x, out_best_y, out_best_value};
        if (peak_q.size() == 0) begin
          $display("%0t: result beat with none pending: found=%0d x=%0d y=%0d value=%0d",
                   $time, got.found, got.x, got.y, got.level);
          err_cnt++;
        end else begin
          want = peak_q.pop_front();
          frame_cnt++;
          if (got !== want) begin
            $display("%0t: result mismatch: expected found=%0d x=%0d y=%0d value=%0d, got found=%0d x=%0d y=%0d value=%0d",
                     $time, want.found, want.x, want.y, want.level,
                     got.found, got.x, got.y, got.level);
            err_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, peak_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic wait_idle();
    do @(posedge clk);
    while (pix_q.size() != 0 || in_valid || peak_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIndexBits-1:0] idx,
                           input logic [CfgDataBits-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_IMAGE_WIDTH:  shadow.image_width = val;
      REG_IMAGE_HEIGHT: shadow.image_height = val;
      REG_BOX_LEFT:     shadow.box_left = val;
      REG_BOX_TOP:      shadow.box_top = val;
      REG_BOX_RIGHT:    shadow.box_right = val;
      REG_BOX_BOTTOM:   shadow.box_bottom = val;
      REG_VALUE_LIMIT:  shadow.value_limit = val[LimitBits-1:0];
      default: ;
    endcase
  endtask

  task automatic setup(input logic [CfgDataBits-1:0] w, input logic [CfgDataBits-1:0] h,
                       input logic [CfgDataBits-1:0] l, input logic [CfgDataBits-1:0] t,
                       input logic [CfgDataBits-1:0] r, input logic [CfgDataBits-1:0] b,
                       input logic [LimitBits-1:0] lim);
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_BOX_LEFT, l);
    write_reg(REG_BOX_TOP, t);
    write_reg(REG_BOX_RIGHT, r);
    write_reg(REG_BOX_BOTTOM, b);
    write_reg(REG_VALUE_LIMIT, {4'b0, lim});
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_random(input int n);
    repeat (n) pix_q.push_back(pick_level(shadow.value_limit));
  endtask

  task automatic push_ramp(input int n);
    for (int i = 0; i < n; i++) pix_q.push_back(8'(i << 1));
  endtask

  initial begin
    int phase;
    int rand_items;
    int ew;
    int eh;
    int n;
    logic [CfgDataBits-1:0] w;
    logic [CfgDataBits-1:0] h;

    shadow = '{RST_IMAGE_WIDTH, RST_IMAGE_HEIGHT, RST_BOX_LEFT, RST_BOX_TOP,
               RST_BOX_RIGHT, RST_BOX_BOTTOM, RST_VALUE_LIMIT};
    col_cnt = '0;
    row_cnt = '0;
    best_col = '0;
    best_row = '0;
    best_lvl = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset config, then shrink the width under a frame in progress
    pix_q = '{8'd3, 8'd255, 8'd0, 8'd255, 8'd17, 8'd254};
    setup(13'd4, 13'd1, 13'd0, 13'd0, 13'd640, 13'd480, 9'd256);
    pix_q.push_back(8'd5);
    // zero size acts as one pixel per frame
    setup(13'd0, 13'd0, 13'd0, 13'd0, 13'd640, 13'd480, 9'd256);
    pix_q = '{8'd0, 8'd255, 8'd1};
    setup(13'd1, 13'd1, 13'd0, 13'd0, 13'd640, 13'd480, 9'd0);
    pix_q.push_back(8'd5);
    setup(13'd1, 13'd1, 13'd0, 13'd0, 13'd640, 13'd480, 9'd1);
    pix_q.push_back(8'd1);
    setup(13'd1, 13'd1, 13'd0, 13'd0, 13'd640, 13'd480, 9'd200);
    pix_q = '{8'd200, 8'd199};
    // negative box edges, oversize right/bottom, ties
    setup(13'd3, 13'd2, 13'h1000, 13'h1FFF, 13'h1FFF, 13'h1FFF, 9'd256);
    pix_q = '{8'd7, 8'd9, 8'd9, 8'd3, 8'd9, 8'd2};
    // empty box
    setup(13'd3, 13'd2, 13'd2, 13'd0, 13'd2, 13'h1FFF, 9'd256);
    pix_q = '{8'd100, 8'd100, 8'd100, 8'd100, 8'd100, 8'd100};

    phase = 0;
    rand_items = 0;
    while (rand_items < RAND_PIXELS) begin
      idle_mode = (rand_items < RAND_PIXELS / 3) ? IDLE_RX_HEAVY :
                  (rand_items < 2 * RAND_PIXELS / 3) ? IDLE_TX_HEAVY : IDLE_OFF;
      if (phase == 6) begin
        setup(13'd4096, 13'd1, 13'h1FFD, 13'd0, 13'h1FFF, 13'd1, 9'd256);
        push_ramp(RAMP_PIXELS);
        rand_items += RAMP_PIXELS;
      end else if (phase == 18) begin
        setup(13'd1, 13'h1FFF, 13'd0, 13'h1FFF, 13'd1, 13'd4096, 9'd256);
        push_ramp(RAMP_PIXELS);
        rand_items += RAMP_PIXELS;
      end else if (phase == 11) begin
        // one-pixel frames so the result path fills while the receiver holds off
        setup(13'd1, 13'd1, 13'd0, 13'd0, 13'h1FFF, 13'h1FFF, 9'd256);
        hold_arm = 1'b1;
        push_random(60);
        rand_items += 60;
      end else begin
        w = pick_dim(8);
        h = pick_dim(6);
        ew = eff_dim(w);
        eh = eff_dim(h);
        setup(w, h, pick_low_edge(ew), pick_low_edge(eh),
              pick_high_edge(ew), pick_high_edge(eh), pick_limit());
        n = ew * eh * int'($urandom_range(1, 3));
        if (phase > 20 && $urandom_range(0, 2) == 0) n += int'($urandom_range(1, ew * eh));
        push_random(n);
        rand_items += n;
      end
      phase++;
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (peak_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, peak_q.size());
      err_cnt++;
    end
    $display("run covered %0d pixels over %0d setups, %0d frame results checked",
             pix_cnt, phase + 7, frame_cnt);
    $display("input back-pressure seen on %0d cycles, %0d mismatches", stall_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
